@@ rtl/ucf_pkg.sv @@
// ----------------------------------------------------------------------------
// ucf_pkg: shared types, constants and helpers of the horizon forecaster
// Q16.16 constants, CORDIC arctangent table, sequencer states, saturation.
// ----------------------------------------------------------------------------
package ucf_pkg;

    localparam int HorizonMax = 64;
    localparam int StepW      = 6;
    localparam int OpW        = 33;
    localparam int ProdW      = 66;
    localparam int WideW      = 52;
    localparam int CordW      = 34;
    localparam int AngW       = 20;
    localparam int UnitW      = 18;
    localparam int CordIters  = 16;
    localparam int RedSteps   = 15;

    localparam logic [30:0] StepTimeRst = 31'd6554;
    localparam logic [30:0] CruiseRst   = 31'd65536;
    localparam logic [6:0]  HorizonRst  = 7'd32;

    localparam logic signed [AngW-1:0] TwoPiQ  = 20'sd411775;
    localparam logic signed [AngW-1:0] PiQ     = 20'sd205887;
    localparam logic signed [AngW-1:0] HalfPiQ = 20'sd102944;

    // offset of 5216 turns keeps the reduced angle non-negative
    localparam logic [32:0] RedOffset = 33'd2147818400;
    localparam logic [32:0] RedDivTop = 33'd6746521600;

    localparam logic signed [CordW-1:0] CordGain = 34'sd652032874;

    typedef logic signed [WideW-1:0] t_wide;

    typedef enum logic [1:0] {
        REG_STEP_TIME = 2'd0,
        REG_CRUISE    = 2'd1,
        REG_HORIZON   = 2'd2
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_H1, S_H2, S_H3, S_H4,
        S_CSTART, S_CWAIT, S_V1, S_V2, S_V3,
        S_E1, S_E2, S_E3, S_E4, S_E5, S_E6,
        S_T1, S_T2, S_T3, S_SQRT, S_DX, S_DY,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        CS_IDLE, CS_REDUCE, CS_ROTATE
    } t_cord_st;

    function automatic logic signed [AngW-1:0] atan_q(input logic [3:0] i);
        logic signed [AngW-1:0] v;
        unique case (i)
            4'd0:  v = 20'sd51472;
            4'd1:  v = 20'sd30385;
            4'd2:  v = 20'sd16055;
            4'd3:  v = 20'sd8150;
            4'd4:  v = 20'sd4091;
            4'd5:  v = 20'sd2047;
            4'd6:  v = 20'sd1024;
            4'd7:  v = 20'sd512;
            4'd8:  v = 20'sd256;
            4'd9:  v = 20'sd128;
            4'd10: v = 20'sd64;
            4'd11: v = 20'sd32;
            4'd12: v = 20'sd16;
            4'd13: v = 20'sd8;
            4'd14: v = 20'sd4;
            4'd15: v = 20'sd2;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide v);
        logic signed [31:0] r;
        if (v > t_wide'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < t_wide'(-64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // rounded Q16.16 product
    function automatic t_wide qround(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-1:0] t;
        t = (p + 66'sd32768) >>> 16;
        return t[WideW-1:0];
    endfunction

endpackage

@@ rtl/ucf_cordic.sv @@
// ----------------------------------------------------------------------------
// ucf_cordic: iterative sine and cosine
// Angle reduction by shifted subtraction of 2*pi, then 16 rotation steps.
// ----------------------------------------------------------------------------
module ucf_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [31:0]                 i_angle,
    output logic                               o_done,
    output logic signed [ucf_pkg::UnitW-1:0]   o_cos,
    output logic signed [ucf_pkg::UnitW-1:0]   o_sin
);

    ucf_pkg::t_cord_st                     r_st, n_st;
    logic [3:0]                            r_cnt;
    logic [32:0]                           r_u, r_d;
    logic signed [ucf_pkg::CordW-1:0]      r_x, r_y;
    logic signed [ucf_pkg::AngW-1:0]       r_z;
    logic                                  r_neg, r_done;
    logic signed [ucf_pkg::UnitW-1:0]      r_cos, r_sin;

    logic [32:0]                           w_u0, w_un;
    logic signed [ucf_pkg::AngW-1:0]       w_a0, w_a1, w_zf;
    logic                                  w_negf;
    logic signed [ucf_pkg::CordW-1:0]      w_xs, w_ys, w_xn, w_yn;
    logic signed [ucf_pkg::AngW-1:0]       w_zn;

    function automatic logic signed [ucf_pkg::UnitW-1:0] to_unit(
        input logic signed [ucf_pkg::CordW-1:0] v, input logic neg);
        logic signed [ucf_pkg::CordW-1:0] t;
        t = (v + 34'sd8192) >>> 14;
        if (neg) begin
            t = -t;
        end
        if (t > 34'sd65536) begin
            t = 34'sd65536;
        end else if (t < -34'sd65536) begin
            t = -34'sd65536;
        end
        return t[ucf_pkg::UnitW-1:0];
    endfunction

    always_comb begin
        w_u0 = {i_angle[31], i_angle} + ucf_pkg::RedOffset;
        w_un = (r_u >= r_d) ? r_u - r_d : r_u;
        w_a0 = {1'b0, w_un[18:0]};
        w_a1 = (w_a0 > ucf_pkg::PiQ) ? w_a0 - ucf_pkg::TwoPiQ : w_a0;
        w_negf = 1'b0;
        w_zf = w_a1;
        if (w_a1 > ucf_pkg::HalfPiQ) begin
            w_zf = w_a1 - ucf_pkg::PiQ;
            w_negf = 1'b1;
        end else if (w_a1 < -ucf_pkg::HalfPiQ) begin
            w_zf = w_a1 + ucf_pkg::PiQ;
            w_negf = 1'b1;
        end
        w_xs = r_x >>> r_cnt;
        w_ys = r_y >>> r_cnt;
        if (!r_z[ucf_pkg::AngW-1]) begin
            w_xn = r_x - w_ys;
            w_yn = r_y + w_xs;
            w_zn = r_z - ucf_pkg::atan_q(r_cnt);
        end else begin
            w_xn = r_x + w_ys;
            w_yn = r_y - w_xs;
            w_zn = r_z + ucf_pkg::atan_q(r_cnt);
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ucf_pkg::CS_IDLE: begin
                if (i_start) n_st = ucf_pkg::CS_REDUCE;
            end
            ucf_pkg::CS_REDUCE: begin
                if (r_cnt == 4'(ucf_pkg::RedSteps - 1)) n_st = ucf_pkg::CS_ROTATE;
            end
            ucf_pkg::CS_ROTATE: begin
                if (r_cnt == 4'(ucf_pkg::CordIters - 1)) n_st = ucf_pkg::CS_IDLE;
            end
            default: n_st = ucf_pkg::CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ucf_pkg::CS_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_st   <= n_st;
            r_done <= 1'b0;
            unique case (r_st)
                ucf_pkg::CS_IDLE: begin
                    r_cnt <= '0;
                end
                ucf_pkg::CS_REDUCE: begin
                    r_cnt <= (n_st == ucf_pkg::CS_ROTATE) ? 4'd0 : r_cnt + 4'd1;
                end
                ucf_pkg::CS_ROTATE: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (n_st == ucf_pkg::CS_IDLE) r_done <= 1'b1;
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ucf_pkg::CS_IDLE: begin
                r_u <= w_u0;
                r_d <= ucf_pkg::RedDivTop;
            end
            ucf_pkg::CS_REDUCE: begin
                r_u <= w_un;
                r_d <= r_d >> 1;
                r_x <= ucf_pkg::CordGain;
                r_y <= '0;
                r_z <= w_zf;
                r_neg <= w_negf;
            end
            ucf_pkg::CS_ROTATE: begin
                r_x <= w_xn;
                r_y <= w_yn;
                r_z <= w_zn;
                if (r_cnt == 4'(ucf_pkg::CordIters - 1)) begin
                    r_cos <= to_unit(w_xn, r_neg);
                    r_sin <= to_unit(w_yn, r_neg);
                end
            end
            default: r_u <= r_u;
        endcase
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

@@ rtl/ucf_isqrt.sv @@
// ----------------------------------------------------------------------------
// ucf_isqrt: floor square root, one result bit per cycle
// 63-bit radicand, 32-bit root.
// ----------------------------------------------------------------------------
module ucf_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] w_sh, w_trial;
    logic        w_ge;

    always_comb begin
        w_sh    = {r_rem[32:0], r_rad[63:62]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = (w_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {1'b0, i_rad};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= w_ge ? w_sh - w_trial : w_sh;
            r_root <= {r_root[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/ucf_div.sv @@
// ----------------------------------------------------------------------------
// ucf_div: restoring divider for the unit direction
// Quotient known below 2^17: the top numerator bits preload the remainder.
// ----------------------------------------------------------------------------
module ucf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [16:0] r_lo, r_quot;
    logic [31:0] r_den;
    logic [32:0] w_sh;
    logic        w_ge;

    always_comb begin
        w_sh = {r_rem[31:0], r_lo[16]};
        w_ge = (w_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {2'b00, i_num[47:17]};
            r_lo   <= i_num[16:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
            r_lo   <= {r_lo[15:0], 1'b0};
            r_quot <= {r_quot[15:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/unicycle_horizon_forecast.sv @@
// ----------------------------------------------------------------------------
// unicycle_horizon_forecast: Euler forecast of a unicycle over a horizon
// Sequencer around one shared 33x33 multiplier, CORDIC, root and divider.
//
//   port group   direction  handshake            content
//   i_in_*       in         valid / stall        seed or step item
//   o_out_*      out        valid / stall        predicted pose and error
//   i_cfg_*      in         valid / ready        register index and data
//
// Step item: heading and position update, CORDIC reduction and rotation, velocity, error.
// Seed item: CORDIC and velocity, then a root and two divides (skipped at zero distance).
// Refused step past the horizon: goes straight to the output state.
// Reset is synchronous; it restores register defaults and clears the state.
// A waiting result sits in the output register; the next result holds in S_OUT until it leaves.
// ----------------------------------------------------------------------------
module unicycle_horizon_forecast (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic signed [31:0]                 i_pose_x,
    input  logic signed [31:0]                 i_pose_y,
    input  logic signed [31:0]                 i_pose_heading,
    input  logic signed [31:0]                 i_target_x,
    input  logic signed [31:0]                 i_target_y,
    input  logic signed [31:0]                 i_turn_rate,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ucf_pkg::StepW-1:0]          o_step_index,
    output logic signed [31:0]                 o_pred_x,
    output logic signed [31:0]                 o_pred_y,
    output logic signed [31:0]                 o_pred_heading,
    output logic signed [31:0]                 o_err_x,
    output logic signed [31:0]                 o_err_y,
    output logic [30:0]                        o_target_distance,
    output logic                               o_zero_distance,
    output logic                               o_past_horizon,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [30:0]                        i_cfg_data
);

    ucf_pkg::t_state                       r_state, n_state;

    logic [30:0]                           r_step_time, r_cruise;
    logic [6:0]                            r_hlen;

    logic signed [31:0]                    r_cur_x, r_cur_y, r_cur_h, r_vel_x, r_vel_y;
    logic signed [31:0]                    r_start_x, r_start_y, r_s;
    logic signed [ucf_pkg::UnitW-1:0]      r_dir_x, r_dir_y;
    logic [30:0]                           r_dist;
    logic [ucf_pkg::StepW-1:0]             r_step_cnt;

    logic                                  r_kind, r_past, r_tzero, r_negx, r_negy;
    logic [30:0]                           r_ax, r_ay;
    logic                                  r_scaled;
    logic signed [31:0]                    r_turn, r_ex, r_ey;
    logic [61:0]                           r_sq;
    logic [31:0]                           r_root;
    logic signed [ucf_pkg::ProdW-1:0]      r_prod;

    logic                                  r_ovalid, r_o_past, r_o_zero;
    logic [ucf_pkg::StepW-1:0]             r_o_step;
    logic signed [31:0]                    r_o_x, r_o_y, r_o_h, r_o_ex, r_o_ey;
    logic [30:0]                           r_o_dist;

    logic                                  w_in_acc, w_load;
    logic signed [ucf_pkg::OpW-1:0]        w_ma, w_mb;
    logic                                  w_cord_start, w_sqrt_start, w_div_start;
    logic                                  w_cord_done, w_sqrt_done, w_div_done;
    logic signed [ucf_pkg::UnitW-1:0]      w_cos, w_sin;
    logic [31:0]                           w_root;
    logic [16:0]                           w_quot;
    logic [47:0]                           w_num;
    logic [31:0]                           w_den;
    logic [62:0]                           w_rad;
    ucf_pkg::t_wide                        w_q;
    logic [6:0]                            w_lim;
    logic signed [32:0]                    w_dx, w_dy;
    logic [32:0]                           w_adx, w_ady;
    logic [30:0]                           w_ax, w_ay;
    logic                                  w_sh1, w_sh2;

    function automatic logic signed [32:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [32:0] zx(input logic [30:0] v);
        return {2'b00, v};
    endfunction

    function automatic logic signed [31:0] err_of(input logic signed [31:0] pos,
        input logic signed [31:0] st, input ucf_pkg::t_wide q);
        logic signed [31:0] ref_pt;
        ref_pt = ucf_pkg::sat32(ucf_pkg::t_wide'(st)
                 + ucf_pkg::t_wide'(ucf_pkg::sat32(q)));
        return ucf_pkg::sat32(ucf_pkg::t_wide'(pos) - ucf_pkg::t_wide'(ref_pt));
    endfunction

    function automatic logic signed [ucf_pkg::UnitW-1:0] dir_of(input logic [16:0] q,
        input logic neg);
        logic [ucf_pkg::UnitW-1:0] m;
        m = (q > 17'd65536) ? 18'd65536 : {1'b0, q};
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // ---------------- input decode ----------------
    assign w_in_acc   = i_in_valid && (r_state == ucf_pkg::S_IDLE);
    assign o_in_stall = (r_state != ucf_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_lim = (r_hlen > 7'(ucf_pkg::HorizonMax)) ? 7'(ucf_pkg::HorizonMax) : r_hlen;

    always_comb begin
        w_dx  = sx(i_target_x) - sx(i_pose_x);
        w_dy  = sx(i_target_y) - sx(i_pose_y);
        w_adx = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
        w_ady = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
        w_sh2 = w_adx[32] | w_ady[32];
        w_sh1 = w_adx[31] | w_ady[31];
        if (w_sh2) begin
            w_ax = w_adx[32:2];
            w_ay = w_ady[32:2];
        end else if (w_sh1) begin
            w_ax = w_adx[31:1];
            w_ay = w_ady[31:1];
        end else begin
            w_ax = w_adx[30:0];
            w_ay = w_ady[30:0];
        end
    end

    // ---------------- shared units ----------------
    assign w_q   = ucf_pkg::qround(r_prod);
    assign w_rad = {1'b0, r_sq} + {1'b0, r_prod[61:0]};
    assign w_den = (r_state == ucf_pkg::S_SQRT) ? w_root : r_root;
    assign w_num = {1'b0, ((r_state == ucf_pkg::S_SQRT) ? r_ax : r_ay), 16'b0}
                   + {17'b0, w_den[31:1]};

    ucf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_angle (r_cur_h),
        .o_done  (w_cord_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    ucf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (w_rad),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    ucf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        w_ma         = '0;
        w_mb         = '0;
        w_cord_start = 1'b0;
        w_sqrt_start = 1'b0;
        w_div_start  = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            ucf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (!i_kind) begin
                        n_state = ucf_pkg::S_CSTART;
                    end else if (7'(r_step_cnt) + 7'd1 >= w_lim) begin
                        n_state = ucf_pkg::S_OUT;
                    end else begin
                        n_state = ucf_pkg::S_H1;
                    end
                end
            end
            ucf_pkg::S_H1: begin
                w_ma = sx(r_turn);
                w_mb = zx(r_step_time);
                n_state = ucf_pkg::S_H2;
            end
            ucf_pkg::S_H2: begin
                w_ma = sx(r_vel_x);
                w_mb = zx(r_step_time);
                n_state = ucf_pkg::S_H3;
            end
            ucf_pkg::S_H3: begin
                w_ma = sx(r_vel_y);
                w_mb = zx(r_step_time);
                n_state = ucf_pkg::S_H4;
            end
            ucf_pkg::S_H4: n_state = ucf_pkg::S_CSTART;
            ucf_pkg::S_CSTART: begin
                w_cord_start = 1'b1;
                n_state = ucf_pkg::S_CWAIT;
            end
            ucf_pkg::S_CWAIT: begin
                if (w_cord_done) n_state = ucf_pkg::S_V1;
            end
            ucf_pkg::S_V1: begin
                w_ma = zx(r_cruise);
                w_mb = 33'(w_cos);
                n_state = ucf_pkg::S_V2;
            end
            ucf_pkg::S_V2: begin
                w_ma = zx(r_cruise);
                w_mb = 33'(w_sin);
                n_state = ucf_pkg::S_V3;
            end
            ucf_pkg::S_V3: n_state = r_kind ? ucf_pkg::S_E1 : ucf_pkg::S_T1;
            ucf_pkg::S_E1: begin
                w_ma = zx(r_cruise);
                w_mb = zx(r_step_time);
                n_state = ucf_pkg::S_E2;
            end
            ucf_pkg::S_E2: begin
                w_ma = {27'b0, r_step_cnt};
                w_mb = 33'(r_dir_x);
                n_state = ucf_pkg::S_E3;
            end
            ucf_pkg::S_E3: begin
                w_ma = sx(r_s);
                w_mb = r_prod[32:0];
                n_state = ucf_pkg::S_E4;
            end
            ucf_pkg::S_E4: begin
                w_ma = {27'b0, r_step_cnt};
                w_mb = 33'(r_dir_y);
                n_state = ucf_pkg::S_E5;
            end
            ucf_pkg::S_E5: begin
                w_ma = sx(r_s);
                w_mb = r_prod[32:0];
                n_state = ucf_pkg::S_E6;
            end
            ucf_pkg::S_E6: n_state = ucf_pkg::S_OUT;
            ucf_pkg::S_T1: begin
                w_ma = zx(r_ax);
                w_mb = zx(r_ax);
                n_state = r_tzero ? ucf_pkg::S_OUT : ucf_pkg::S_T2;
            end
            ucf_pkg::S_T2: begin
                w_ma = zx(r_ay);
                w_mb = zx(r_ay);
                n_state = ucf_pkg::S_T3;
            end
            ucf_pkg::S_T3: begin
                w_sqrt_start = 1'b1;
                n_state = ucf_pkg::S_SQRT;
            end
            ucf_pkg::S_SQRT: begin
                if (w_sqrt_done) begin
                    w_div_start = 1'b1;
                    n_state = ucf_pkg::S_DX;
                end
            end
            ucf_pkg::S_DX: begin
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_state = ucf_pkg::S_DY;
                end
            end
            ucf_pkg::S_DY: begin
                if (w_div_done) n_state = ucf_pkg::S_OUT;
            end
            ucf_pkg::S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    w_load = 1'b1;
                    n_state = ucf_pkg::S_IDLE;
                end
            end
            default: n_state = ucf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= ucf_pkg::StepTimeRst;
            r_cruise    <= ucf_pkg::CruiseRst;
            r_hlen      <= ucf_pkg::HorizonRst;
        end else if (i_cfg_valid) begin
            unique case (ucf_pkg::t_reg_idx'(i_cfg_index))
                ucf_pkg::REG_STEP_TIME: r_step_time <= i_cfg_data;
                ucf_pkg::REG_CRUISE:    r_cruise    <= i_cfg_data;
                ucf_pkg::REG_HORIZON:   r_hlen      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ---------------- forecast state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_cur_h    <= '0;
            r_vel_x    <= '0;
            r_vel_y    <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_dir_x    <= '0;
            r_dir_y    <= '0;
            r_dist     <= '0;
            r_step_cnt <= '0;
        end else begin
            unique case (r_state)
                ucf_pkg::S_IDLE: begin
                    if (w_in_acc && !i_kind) begin
                        r_cur_x    <= i_pose_x;
                        r_cur_y    <= i_pose_y;
                        r_cur_h    <= i_pose_heading;
                        r_start_x  <= i_pose_x;
                        r_start_y  <= i_pose_y;
                        r_step_cnt <= '0;
                    end
                end
                ucf_pkg::S_H2: r_cur_h <= ucf_pkg::sat32(ucf_pkg::t_wide'(r_cur_h) + w_q);
                ucf_pkg::S_H3: r_cur_x <= ucf_pkg::sat32(ucf_pkg::t_wide'(r_cur_x) + w_q);
                ucf_pkg::S_H4: begin
                    r_cur_y    <= ucf_pkg::sat32(ucf_pkg::t_wide'(r_cur_y) + w_q);
                    r_step_cnt <= r_step_cnt + 6'd1;
                end
                ucf_pkg::S_V2: r_vel_x <= ucf_pkg::sat32(w_q);
                ucf_pkg::S_V3: r_vel_y <= ucf_pkg::sat32(w_q);
                ucf_pkg::S_T1: begin
                    if (r_tzero) begin
                        r_dist  <= '0;
                        r_dir_x <= '0;
                        r_dir_y <= '0;
                    end
                end
                ucf_pkg::S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_dist <= (r_scaled || w_root[31]) ? 31'h7FFFFFFF : w_root[30:0];
                    end
                end
                ucf_pkg::S_DX: if (w_div_done) r_dir_x <= dir_of(w_quot, r_negx);
                ucf_pkg::S_DY: if (w_div_done) r_dir_y <= dir_of(w_quot, r_negy);
                default: ;
            endcase
        end
    end

    // ---------------- item scratch ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0;
            r_past <= 1'b0;
        end else if (w_in_acc) begin
            r_kind <= i_kind;
            r_past <= i_kind && (7'(r_step_cnt) + 7'd1 >= w_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ucf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_turn   <= i_turn_rate;
                    r_ax     <= w_ax;
                    r_ay     <= w_ay;
                    r_scaled <= w_sh1 | w_sh2;
                    r_tzero  <= (w_dx == '0) && (w_dy == '0);
                    r_negx   <= w_dx[32];
                    r_negy   <= w_dy[32];
                    r_ex     <= '0;
                    r_ey     <= '0;
                end
            end
            ucf_pkg::S_E2: r_s  <= ucf_pkg::sat32(w_q);
            ucf_pkg::S_E4: r_ex <= err_of(r_cur_x, r_start_x, w_q);
            ucf_pkg::S_E6: r_ey <= err_of(r_cur_y, r_start_y, w_q);
            ucf_pkg::S_T2: r_sq <= r_prod[61:0];
            ucf_pkg::S_SQRT: if (w_sqrt_done) r_root <= w_root;
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_step <= r_step_cnt;
            r_o_x    <= r_cur_x;
            r_o_y    <= r_cur_y;
            r_o_h    <= r_cur_h;
            r_o_ex   <= r_ex;
            r_o_ey   <= r_ey;
            r_o_dist <= r_dist;
            r_o_zero <= (r_dist == '0);
            r_o_past <= r_past;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_step_index      = r_o_step;
    assign o_pred_x          = r_o_x;
    assign o_pred_y          = r_o_y;
    assign o_pred_heading    = r_o_h;
    assign o_err_x           = r_o_ex;
    assign o_err_y           = r_o_ey;
    assign o_target_distance = r_o_dist;
    assign o_zero_distance   = r_o_zero;
    assign o_past_horizon    = r_o_past;

    // ---------------- assertions ----------------
    a_past_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_past_horizon |-> o_err_x == '0 && o_err_y == '0)
        else $error("refused step carries a tracking error");

    a_seed_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_past_horizon && o_step_index == '0
        |-> o_err_x == '0 && o_err_y == '0)
        else $error("seed result carries a tracking error");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != ucf_pkg::S_IDLE)
        else $error("sequencer idle after a transfer");

    a_cord_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cord_done |-> r_state == ucf_pkg::S_CWAIT)
        else $error("CORDIC finished outside its wait state");

endmodule

@@ verif/unicycle_horizon_forecast_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unicycle_horizon_forecast_tb: self-checking bench of the horizon forecaster
// Drives seed and step items under several idle/stall mixes, predicts every
// result with an independent fixed-point model and checks each field in order.
// ----------------------------------------------------------------------------
module unicycle_horizon_forecast_tb;

    typedef struct {
        logic        kind;
        logic [31:0] px, py, ph, tx, ty, tr;
    } t_item;

    typedef struct {
        logic [5:0]  idx;
        logic [31:0] x, y, hd, ex, ey;
        logic [30:0] tdist;
        logic        zdist, past;
    } t_pose;

    class forecast_sb;
        longint unsigned dt, spd, hlen;
        longint cx, cy, ch, vx, vy, sx, sy, ux, uy, dh;
        int unsigned cnt;
        t_pose pending[$];
        int errs;

        function new();
            dt = 6554; spd = 65536; hlen = 32;
            cx = 0; cy = 0; ch = 0; vx = 0; vy = 0;
            sx = 0; sy = 0; ux = 0; uy = 0; dh = 0; cnt = 0; errs = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint qm(longint a, longint b);
            return (a * b + 32768) >>> 16;
        endfunction

        function longint unit_clamp(longint v);
            if (v > 65536) return 65536;
            if (v < -65536) return -65536;
            return v;
        endfunction

        function void velocity();
            longint a, x, y, nx;
            bit flip;
            int atn[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
            a = ch % 411775;
            x = 652032874; y = 0; flip = 0;
            if (a < 0) a += 411775;
            if (a > 205887) a -= 411775;
            if (a > 102944) begin
                a -= 205887; flip = 1;
            end else if (a < -102944) begin
                a += 205887; flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                if (a >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i); a -= atn[i];
                end else begin
                    nx = x + (y >>> i); y = y - (x >>> i); a += atn[i];
                end
                x = nx;
            end
            x = (x + 8192) >>> 14;
            y = (y + 8192) >>> 14;
            if (flip) begin
                x = -x; y = -y;
            end
            vx = sat(qm(longint'(spd), unit_clamp(x)));
            vy = sat(qm(longint'(spd), unit_clamp(y)));
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint unit_of(longint unsigned m, bit neg, longint unsigned r);
            longint unsigned q;
            q = ((m << 16) + r / 2) / r;
            if (q > 65536) q = 65536;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void aim(longint dx, longint dy);
            longint unsigned ax, ay, r;
            bit halved;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            halved = 0;
            if (ax == 0 && ay == 0) begin
                ux = 0; uy = 0; dh = 0;
                return;
            end
            while (ax >= 64'h80000000 || ay >= 64'h80000000) begin
                ax >>= 1; ay >>= 1; halved = 1;
            end
            r = root(ax * ax + ay * ay);
            dh = (halved || r > 64'd2147483647) ? 2147483647 : longint'(r);
            ux = unit_of(ax, dx < 0, r);
            uy = unit_of(ay, dy < 0, r);
        endfunction

        function longint track(longint p, longint s0, longint u);
            longint s, q;
            s = sat(qm(longint'(spd), longint'(dt)));
            q = sat(qm(s * longint'(cnt), u));
            return sat(p - sat(s0 + q));
        endfunction

        function void write_reg(ucf_pkg::t_reg_idx r, logic [30:0] v);
            case (r)
                ucf_pkg::REG_STEP_TIME: dt = 64'(v);
                ucf_pkg::REG_CRUISE:    spd = 64'(v);
                ucf_pkg::REG_HORIZON:   hlen = 64'(v[6:0]);
                default: ;
            endcase
        endfunction

        function void note_item(t_item it);
            t_pose e;
            longint unsigned lim;
            longint nx, ny;
            e.ex = 0; e.ey = 0; e.past = 0;
            if (it.kind == 1'b0) begin
                cx = signed'(it.px); cy = signed'(it.py); ch = signed'(it.ph);
                sx = cx; sy = cy;
                velocity();
                aim(longint'(signed'(it.tx)) - cx, longint'(signed'(it.ty)) - cy);
                cnt = 0;
            end else begin
                lim = hlen > 64 ? 64 : hlen;
                if (cnt + 1 >= lim) e.past = 1;
                else begin
                    nx = sat(cx + qm(vx, longint'(dt)));
                    ny = sat(cy + qm(vy, longint'(dt)));
                    ch = sat(ch + qm(longint'(signed'(it.tr)), longint'(dt)));
                    cx = nx; cy = ny;
                    velocity();
                    cnt = (cnt + 1) & 63;
                    e.ex = 32'(track(cx, sx, ux));
                    e.ey = 32'(track(cy, sy, uy));
                end
            end
            e.idx = 6'(cnt); e.x = 32'(cx); e.y = 32'(cy); e.hd = 32'(ch);
            e.tdist = dh[30:0]; e.zdist = (dh == 0);
            pending.push_back(e);
        endfunction

        function void check_result(t_pose a);
            t_pose e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errs++;
                return;
            end
            e = pending.pop_front();
            if (a.idx !== e.idx) begin
                $error("step_index exp %0d got %0d", e.idx, a.idx); errs++;
            end
            if (a.x !== e.x) begin
                $error("pred_x exp %h got %h", e.x, a.x); errs++;
            end
            if (a.y !== e.y) begin
                $error("pred_y exp %h got %h", e.y, a.y); errs++;
            end
            if (a.hd !== e.hd) begin
                $error("pred_heading exp %h got %h", e.hd, a.hd); errs++;
            end
            if (a.ex !== e.ex) begin
                $error("err_x exp %h got %h", e.ex, a.ex); errs++;
            end
            if (a.ey !== e.ey) begin
                $error("err_y exp %h got %h", e.ey, a.ey); errs++;
            end
            if (a.tdist !== e.tdist) begin
                $error("target_distance exp %h got %h", e.tdist, a.tdist); errs++;
            end
            if (a.zdist !== e.zdist) begin
                $error("zero_distance exp %b got %b", e.zdist, a.zdist); errs++;
            end
            if (a.past !== e.past) begin
                $error("past_horizon exp %b got %b", e.past, a.past); errs++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_stall, i_kind;
    logic [31:0] i_pose_x, i_pose_y, i_pose_heading, i_target_x, i_target_y, i_turn_rate;
    logic        o_out_valid, i_out_stall;
    logic [5:0]  o_step_index;
    logic [31:0] o_pred_x, o_pred_y, o_pred_heading, o_err_x, o_err_y;
    logic [30:0] o_target_distance;
    logic        o_zero_distance, o_past_horizon;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [30:0] i_cfg_data;

    unicycle_horizon_forecast dut (.*);

    forecast_sb sb;
    int send_idle, recv_stall;
    int quiet;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_pose a;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            a.idx = o_step_index; a.x = o_pred_x; a.y = o_pred_y; a.hd = o_pred_heading;
            a.ex = o_err_x; a.ey = o_err_y; a.tdist = o_target_distance;
            a.zdist = o_zero_distance; a.past = o_past_horizon;
            sb.check_result(a);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays high across back-to-back transfers; idling and drain drop it
    task automatic send(t_item it);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= it.kind;
        i_pose_x <= it.px; i_pose_y <= it.py; i_pose_heading <= it.ph;
        i_target_x <= it.tx; i_target_y <= it.ty; i_turn_rate <= it.tr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
    endtask

    task automatic set_reg(ucf_pkg::t_reg_idx r, logic [30:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(r, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1200000)) - 600000);
        endcase
    endfunction

    function automatic t_item seed_of(logic [31:0] x, logic [31:0] y, logic [31:0] h,
                                      logic [31:0] tx, logic [31:0] ty);
        t_item it;
        it.kind = 0; it.px = x; it.py = y; it.ph = h; it.tx = tx; it.ty = ty;
        it.tr = $urandom;
        return it;
    endfunction

    function automatic t_item step_of(logic [31:0] tr);
        t_item it;
        it.kind = 1; it.tr = tr;
        it.px = $urandom; it.py = $urandom; it.ph = $urandom;
        it.tx = $urandom; it.ty = $urandom;
        return it;
    endfunction

    function automatic t_item rnd_seed();
        t_item it;
        it = seed_of(rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val());
        if ($urandom_range(9) == 0) begin
            it.tx = it.px; it.ty = it.py;
        end
        return it;
    endfunction

    function automatic logic [31:0] rnd_turn();
        return $urandom_range(3) == 0 ? $urandom
                                      : 32'($signed($urandom_range(0, 400000)) - 200000);
    endfunction

    initial begin
        logic [30:0] dts[5]  = '{31'd1, 31'd6554, 31'd65536, 31'd700000, 31'h7FFFFFFF};
        logic [30:0] spds[5] = '{31'd0, 31'd65536, 31'd300000, 31'd5000000, 31'h7FFFFFFF};
        logic [30:0] hls[6]  = '{31'd2, 31'd64, 31'd5, 31'd32, 31'd127, 31'd0};
        int mode;
        sb = new();
        i_rst_n = 0; i_in_valid = 0; i_kind = 0; i_cfg_valid = 0;
        i_cfg_index = ucf_pkg::REG_STEP_TIME; i_cfg_data = 0;
        i_pose_x = 0; i_pose_y = 0; i_pose_heading = 0;
        i_target_x = 0; i_target_y = 0; i_turn_rate = 0;
        send_idle = 0; recv_stall = 0; quiet = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: step before seed, extremes, zero distance, far target
        send(step_of(32'h00010000));
        send(seed_of(0, 0, 0, 32'h00050000, 32'h00030000));
        send(step_of(32'h7FFFFFFF));
        send(step_of(32'h80000000));
        send(step_of(0));
        send(seed_of(32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00010000, 32'hFFFF0000));
        send(step_of(32'h00008000));
        send(seed_of(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
        send(step_of(32'hFFFF0000));
        send(seed_of(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
        send(step_of(32'h00030000));
        send(seed_of(32'h00001000, 0, 32'h0003243F, 32'h00001000, 32'h7FFFFFFF));
        send(step_of(32'h12345678));
        drain();
        set_reg(ucf_pkg::REG_HORIZON, 31'd2);
        send(step_of(32'h00010000));
        send(step_of(32'h00010000));
        drain();
        set_reg(ucf_pkg::REG_HORIZON, 31'd0);
        send(step_of(32'h00010000));
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            mode = ph % 4;
            send_idle  = (mode == 1 || mode == 3) ? (mode == 3 ? 36 : 63) : 0;
            recv_stall = (mode == 2 || mode == 3) ? (mode == 3 ? 36 : 63) : 0;
            set_reg(ucf_pkg::REG_STEP_TIME,
                    ph < 10 ? dts[ph % 5] : 31'($urandom_range(1, 200000)));
            set_reg(ucf_pkg::REG_CRUISE, ph < 10 ? spds[(ph * 3) % 5] : 31'($urandom));
            set_reg(ucf_pkg::REG_HORIZON, hls[ph % 6]);
            for (int n = 0; n < 125; ) begin
                send(rnd_seed());
                n++;
                for (int k = $urandom_range(0, 70); k > 0 && n < 125; k--) begin
                    send(step_of(rnd_turn()));
                    n++;
                end
            end
            drain();
        end

        if (sb.errs == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ unicycle_horizon_forecast.f @@
rtl/ucf_pkg.sv
rtl/ucf_cordic.sv
rtl/ucf_isqrt.sv
rtl/ucf_div.sv
rtl/unicycle_horizon_forecast.sv
verif/unicycle_horizon_forecast_tb.sv
